/* src/stt_pkg.sv */
// Shared types, character codes, token kinds and helper functions for the source tokenizer.
package stt_pkg;

  localparam int POS_BITS   = 24;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;
  localparam int CNT_W      = 3;

  typedef logic [POS_BITS-1:0] pos_t;
  typedef logic [5:0][7:0]     word_t;

  typedef enum logic [6:0] {
    MODE_IDLE    = 7'b0000001,
    MODE_COMMENT = 7'b0000010,
    MODE_WORD    = 7'b0000100,
    MODE_NUMBER  = 7'b0001000,
    MODE_STRING  = 7'b0010000,
    MODE_OPER    = 7'b0100000,
    MODE_ERROR   = 7'b1000000
  } mode_t;

  typedef struct packed {
    logic [4:0] kind;
    pos_t       start;
    pos_t       len;
    pos_t       line;
    logic [1:0] err;
    logic       last;
  } res_t;

  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_UNKNOWN = 2'd1;
  localparam logic [1:0] ERR_UNTERM  = 2'd2;

  localparam logic [4:0] KIND_EOF     = 5'd0;
  localparam logic [4:0] KIND_IDENT   = 5'd1;
  localparam logic [4:0] KIND_NUMBER  = 5'd2;
  localparam logic [4:0] KIND_STRING  = 5'd3;
  localparam logic [4:0] KIND_KW_BASE = 5'd4;
  localparam logic [4:0] KIND_PLUS    = 5'd11;
  localparam logic [4:0] KIND_MINUS   = 5'd12;
  localparam logic [4:0] KIND_STAR    = 5'd13;
  localparam logic [4:0] KIND_SLASH   = 5'd14;
  localparam logic [4:0] KIND_ASSIGN  = 5'd15;
  localparam logic [4:0] KIND_EQ      = 5'd16;
  localparam logic [4:0] KIND_NE      = 5'd17;
  localparam logic [4:0] KIND_LT      = 5'd18;
  localparam logic [4:0] KIND_GT      = 5'd19;
  localparam logic [4:0] KIND_LE      = 5'd20;
  localparam logic [4:0] KIND_GE      = 5'd21;
  localparam logic [4:0] KIND_LPAREN  = 5'd22;
  localparam logic [4:0] KIND_RPAREN  = 5'd23;
  localparam logic [4:0] KIND_LBRACE  = 5'd24;
  localparam logic [4:0] KIND_RBRACE  = 5'd25;
  localparam logic [4:0] KIND_SEMI    = 5'd26;
  localparam logic [4:0] KIND_COMMA   = 5'd27;

  localparam logic [1:0] OP_ASSIGN = 2'd0;
  localparam logic [1:0] OP_BANG   = 2'd1;
  localparam logic [1:0] OP_LT     = 2'd2;
  localparam logic [1:0] OP_GT     = 2'd3;

  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_UNDER  = 8'h5F;

  // keyword text, first character in byte 0
  localparam int    KW_NUM = 7;
  localparam word_t KW_TEXT [KW_NUM] = '{
    {8'h00, "a", "b", "m", "a", "n"},
    {"o", "n", "e", "n", "a", "m"},
    {"a", "k", "i", "d", "n", "a"},
    {8'h00, 8'h00, "a", "m", "a", "k"},
    {8'h00, 8'h00, 8'h00, "o", "i", "s"},
    {"i", "t", "a", "k", "a", "w"},
    {8'h00, 8'h00, 8'h00, 8'h00, "i", "n"}
  };
  localparam logic [2:0] KW_LEN [KW_NUM] = '{3'd5, 3'd6, 3'd6, 3'd4, 3'd3, 3'd6, 3'd2};

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == CH_UNDER;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic is_op_char(input logic [7:0] c);
    return c == CH_EQUAL || c == CH_BANG || c == CH_LT || c == CH_GT;
  endfunction

  function automatic logic [1:0] op_index(input logic [7:0] c);
    logic [1:0] k;
    case (c)
      CH_BANG: k = OP_BANG;
      CH_LT:   k = OP_LT;
      CH_GT:   k = OP_GT;
      default: k = OP_ASSIGN;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] op_single(input logic [1:0] k);
    logic [4:0] r;
    case (k)
      OP_LT:   r = KIND_LT;
      OP_GT:   r = KIND_GT;
      OP_BANG: r = KIND_EOF;
      default: r = KIND_ASSIGN;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] op_double(input logic [1:0] k);
    logic [4:0] r;
    case (k)
      OP_BANG: r = KIND_NE;
      OP_LT:   r = KIND_LE;
      OP_GT:   r = KIND_GE;
      default: r = KIND_EQ;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] single_kind(input logic [7:0] c);
    logic [4:0] r;
    case (c)
      CH_PLUS:   r = KIND_PLUS;
      CH_MINUS:  r = KIND_MINUS;
      CH_STAR:   r = KIND_STAR;
      CH_SLASH:  r = KIND_SLASH;
      CH_LPAREN: r = KIND_LPAREN;
      CH_RPAREN: r = KIND_RPAREN;
      CH_LBRACE: r = KIND_LBRACE;
      CH_RBRACE: r = KIND_RBRACE;
      CH_SEMI:   r = KIND_SEMI;
      CH_COMMA:  r = KIND_COMMA;
      default:   r = KIND_EOF;
    endcase
    return r;
  endfunction

  // identifier or keyword kind for the buffered word
  function automatic logic [4:0] word_kind(input word_t buf_w, input logic [2:0] len);
    logic [4:0] r;
    logic       hit;
    r = KIND_IDENT;
    for (int k = KW_NUM - 1; k >= 0; k--) begin
      hit = (len == KW_LEN[k]);
      for (int i = 0; i < 6; i++) begin
        if (3'(i) < KW_LEN[k] && buf_w[i] != KW_TEXT[k][i]) begin
          hit = 1'b0;
        end
      end
      if (hit) begin
        r = KIND_KW_BASE + 5'(k);
      end
    end
    return r;
  endfunction

  function automatic pos_t sat_inc(input pos_t x);
    return (x == '1) ? x : x + 1'b1;
  endfunction

  function automatic res_t mk_res(input logic [4:0] kind, input pos_t start, input pos_t len,
                                  input pos_t line, input logic [1:0] err);
    res_t r;
    r.kind  = kind;
    r.start = start;
    r.len   = len;
    r.line  = line;
    r.err   = err;
    r.last  = 1'b0;
    return r;
  endfunction

endpackage

/* src/source_text_tokenizer_core.sv */
// Top level of the byte-serial source tokenizer. Takes one source byte (or the end marker)
// per cycle while in_ready is high; scanner state is updated in the accepting cycle and the
// up to two tokens a byte produces are written to a four-entry result queue that drains one
// token per cycle while out_ready is high. in_ready stays high while the queue has room for
// two tokens, so with out_ready high a steady stream of one byte per cycle flows without
// stalls; only bytes that emit two tokens (a token closed by a one-character token, or the
// end marker after an open token) add one extra token of queue occupancy. Errors return
// token kind 0 with a nonzero error code; after an error bytes are dropped until the end
// marker, which always closes with an EOF token and restores the reset state.
module source_text_tokenizer_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_source_byte,
  input  logic        in_is_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [4:0]  out_token_kind,
  output logic [23:0] out_start_offset,
  output logic [23:0] out_lexeme_length,
  output logic [23:0] out_line_number,
  output logic [1:0]  out_error_code,
  output logic        out_last_of_run
);

  stt_pkg::mode_t mode_r, mode_nxt;
  logic [1:0]     pend_r, pend_nxt;
  stt_pkg::pos_t  bp_r, bp_nxt;
  stt_pkg::pos_t  ts_r, ts_nxt;
  stt_pkg::pos_t  line_r, line_nxt;
  stt_pkg::word_t wbuf_r, wbuf_nxt;
  logic [2:0]     wlen_r, wlen_nxt;

  stt_pkg::res_t  fifo_r [stt_pkg::FIFO_DEPTH];
  logic [stt_pkg::FIFO_AW-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [stt_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;

  logic          acc, pop;
  logic [7:0]    c;
  stt_pkg::pos_t bp_inc, run_len;
  logic          pre_v, idl_v, do_idle;
  stt_pkg::res_t pre, idl, slot0, slot1;
  logic [1:0]    nres;

  assign acc     = in_valid && in_ready;
  assign pop     = out_valid && out_ready;
  assign c       = in_source_byte;
  assign bp_inc  = stt_pkg::sat_inc(bp_r);
  assign run_len = (bp_r >= ts_r) ? bp_r - ts_r : '0;

  always_comb begin
    mode_nxt = mode_r;
    pend_nxt = pend_r;
    bp_nxt   = bp_r;
    ts_nxt   = ts_r;
    line_nxt = line_r;
    wbuf_nxt = wbuf_r;
    wlen_nxt = wlen_r;
    pre_v    = 1'b0;
    idl_v    = 1'b0;
    do_idle  = 1'b0;
    pre      = stt_pkg::mk_res(stt_pkg::KIND_EOF, bp_r, '0, line_r, stt_pkg::ERR_NONE);
    idl      = pre;

    if (in_is_end) begin
      unique case (mode_r)
        stt_pkg::MODE_WORD: begin
          pre_v = 1'b1;
          pre   = stt_pkg::mk_res(stt_pkg::word_kind(wbuf_r, wlen_r), ts_r, run_len, line_r,
                                  stt_pkg::ERR_NONE);
        end
        stt_pkg::MODE_NUMBER: begin
          pre_v = 1'b1;
          pre   = stt_pkg::mk_res(stt_pkg::KIND_NUMBER, ts_r, run_len, line_r,
                                  stt_pkg::ERR_NONE);
        end
        stt_pkg::MODE_STRING: begin
          pre_v = 1'b1;
          pre   = stt_pkg::mk_res(stt_pkg::KIND_EOF, ts_r, run_len, line_r,
                                  stt_pkg::ERR_UNTERM);
        end
        stt_pkg::MODE_OPER: begin
          pre_v = 1'b1;
          if (pend_r == stt_pkg::OP_BANG) begin
            pre = stt_pkg::mk_res(stt_pkg::KIND_EOF, ts_r, 24'd1, line_r,
                                  stt_pkg::ERR_UNKNOWN);
          end else begin
            pre = stt_pkg::mk_res(stt_pkg::op_single(pend_r), ts_r, 24'd1, line_r,
                                  stt_pkg::ERR_NONE);
          end
        end
        default: begin
        end
      endcase
      idl_v    = 1'b1;
      idl      = stt_pkg::mk_res(stt_pkg::KIND_EOF, bp_r, '0, line_r, stt_pkg::ERR_NONE);
      mode_nxt = stt_pkg::MODE_IDLE;
      pend_nxt = '0;
      bp_nxt   = '0;
      ts_nxt   = '0;
      line_nxt = stt_pkg::pos_t'(1);
      wlen_nxt = '0;
    end else begin
      unique case (mode_r)
        stt_pkg::MODE_IDLE: begin
          do_idle = 1'b1;
        end
        stt_pkg::MODE_COMMENT: begin
          if (c == stt_pkg::CH_NL) begin
            line_nxt = stt_pkg::sat_inc(line_r);
            mode_nxt = stt_pkg::MODE_IDLE;
          end
          bp_nxt = bp_inc;
        end
        stt_pkg::MODE_STRING: begin
          if (c == stt_pkg::CH_QUOTE) begin
            pre_v    = 1'b1;
            pre      = stt_pkg::mk_res(stt_pkg::KIND_STRING, ts_r, run_len, line_r,
                                       stt_pkg::ERR_NONE);
            mode_nxt = stt_pkg::MODE_IDLE;
          end else if (c == stt_pkg::CH_NL) begin
            line_nxt = stt_pkg::sat_inc(line_r);
          end
          bp_nxt = bp_inc;
        end
        stt_pkg::MODE_WORD: begin
          if (stt_pkg::is_alpha(c) || stt_pkg::is_digit(c)) begin
            if (wlen_r < 3'd6) begin
              wbuf_nxt[wlen_r] = c;
            end
            if (wlen_r < 3'd7) begin
              wlen_nxt = wlen_r + 3'd1;
            end
            bp_nxt = bp_inc;
          end else begin
            pre_v    = 1'b1;
            pre      = stt_pkg::mk_res(stt_pkg::word_kind(wbuf_r, wlen_r), ts_r, run_len,
                                       line_r, stt_pkg::ERR_NONE);
            mode_nxt = stt_pkg::MODE_IDLE;
            do_idle  = 1'b1;
          end
        end
        stt_pkg::MODE_NUMBER: begin
          if (stt_pkg::is_digit(c)) begin
            bp_nxt = bp_inc;
          end else begin
            pre_v    = 1'b1;
            pre      = stt_pkg::mk_res(stt_pkg::KIND_NUMBER, ts_r, run_len, line_r,
                                       stt_pkg::ERR_NONE);
            mode_nxt = stt_pkg::MODE_IDLE;
            do_idle  = 1'b1;
          end
        end
        stt_pkg::MODE_OPER: begin
          pre_v = 1'b1;
          if (c == stt_pkg::CH_EQUAL) begin
            pre      = stt_pkg::mk_res(stt_pkg::op_double(pend_r), ts_r, 24'd2, line_r,
                                       stt_pkg::ERR_NONE);
            mode_nxt = stt_pkg::MODE_IDLE;
            bp_nxt   = bp_inc;
          end else if (pend_r == stt_pkg::OP_BANG) begin
            pre      = stt_pkg::mk_res(stt_pkg::KIND_EOF, ts_r, 24'd1, line_r,
                                       stt_pkg::ERR_UNKNOWN);
            mode_nxt = stt_pkg::MODE_ERROR;
            bp_nxt   = bp_inc;
          end else begin
            pre      = stt_pkg::mk_res(stt_pkg::op_single(pend_r), ts_r, 24'd1, line_r,
                                       stt_pkg::ERR_NONE);
            mode_nxt = stt_pkg::MODE_IDLE;
            do_idle  = 1'b1;
          end
        end
        default: begin
          bp_nxt = bp_inc;
        end
      endcase

      if (do_idle) begin
        if (c == stt_pkg::CH_NL) begin
          line_nxt = stt_pkg::sat_inc(line_r);
        end else if (stt_pkg::is_space(c)) begin
          mode_nxt = stt_pkg::MODE_IDLE;
        end else if (c == stt_pkg::CH_HASH) begin
          mode_nxt = stt_pkg::MODE_COMMENT;
        end else if (stt_pkg::is_alpha(c)) begin
          mode_nxt    = stt_pkg::MODE_WORD;
          ts_nxt      = bp_r;
          wbuf_nxt[0] = c;
          wlen_nxt    = 3'd1;
        end else if (stt_pkg::is_digit(c)) begin
          mode_nxt = stt_pkg::MODE_NUMBER;
          ts_nxt   = bp_r;
        end else if (c == stt_pkg::CH_QUOTE) begin
          mode_nxt = stt_pkg::MODE_STRING;
          ts_nxt   = bp_inc;
        end else if (stt_pkg::is_op_char(c)) begin
          mode_nxt = stt_pkg::MODE_OPER;
          pend_nxt = stt_pkg::op_index(c);
          ts_nxt   = bp_r;
        end else if (stt_pkg::single_kind(c) != stt_pkg::KIND_EOF) begin
          idl_v = 1'b1;
          idl   = stt_pkg::mk_res(stt_pkg::single_kind(c), bp_r, 24'd1, line_r,
                                  stt_pkg::ERR_NONE);
        end else begin
          idl_v    = 1'b1;
          idl      = stt_pkg::mk_res(stt_pkg::KIND_EOF, bp_r, 24'd1, line_r,
                                     stt_pkg::ERR_UNKNOWN);
          mode_nxt = stt_pkg::MODE_ERROR;
        end
        bp_nxt = bp_inc;
      end
    end
  end

  // pack the produced tokens in order and flag the final one
  always_comb begin
    slot0 = pre_v ? pre : idl;
    slot1 = idl;
    nres  = {1'b0, pre_v} + {1'b0, idl_v};
    if (nres == 2'd2) begin
      slot1.last = 1'b1;
    end else begin
      slot0.last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= stt_pkg::MODE_IDLE;
      pend_r <= '0;
      bp_r   <= '0;
      ts_r   <= '0;
      line_r <= stt_pkg::pos_t'(1);
      wlen_r <= '0;
    end else if (acc) begin
      mode_r <= mode_nxt;
      pend_r <= pend_nxt;
      bp_r   <= bp_nxt;
      ts_r   <= ts_nxt;
      line_r <= line_nxt;
      wlen_r <= wlen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      wbuf_r <= wbuf_nxt;
    end
  end

  // result queue
  assign in_ready  = cnt_r <= stt_pkg::CNT_W'(stt_pkg::FIFO_DEPTH - 2);
  assign out_valid = cnt_r != '0;

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (acc) begin
      wr_nxt  = wr_r + stt_pkg::FIFO_AW'(nres);
      cnt_nxt = cnt_nxt + stt_pkg::CNT_W'(nres);
    end
    if (pop) begin
      rd_nxt  = rd_r + 1'b1;
      cnt_nxt = cnt_nxt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && nres != 2'd0) begin
      fifo_r[wr_r] <= slot0;
    end
    if (acc && nres == 2'd2) begin
      fifo_r[wr_r + 1'b1] <= slot1;
    end
  end

  assign out_token_kind    = fifo_r[rd_r].kind;
  assign out_start_offset  = fifo_r[rd_r].start;
  assign out_lexeme_length = fifo_r[rd_r].len;
  assign out_line_number   = fifo_r[rd_r].line;
  assign out_error_code    = fifo_r[rd_r].err;
  assign out_last_of_run   = fifo_r[rd_r].last;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= stt_pkg::CNT_W'(stt_pkg::FIFO_DEPTH))
    else $error("result queue overflow");

  a_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_is_end) |=> (mode_r == stt_pkg::MODE_IDLE && bp_r == '0
                            && line_r == stt_pkg::pos_t'(1)))
    else $error("end marker did not restore scanner state");

  a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    line_r != '0)
    else $error("line count reached zero");

  a_err_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_error_code != stt_pkg::ERR_NONE) |-> out_token_kind == stt_pkg::KIND_EOF)
    else $error("error token carries a nonzero kind");

endmodule
